// ----- hdl/mbrtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, codes and word layout for the Modbus RTU frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrtu_pkg;

  // default frame size limits
  localparam int unsigned FRAME_MAX_DEF = 256;
  localparam int unsigned FRAME_MIN_DEF = 4;

  // register reset values, broadcast address and CRC constants
  localparam logic [7:0]  UNIT_ADDR_RST  = 8'd1;
  localparam logic [31:0] CHAR_GAP_RST   = 32'd750;
  localparam logic [31:0] FRAME_GAP_RST  = 32'd1750;
  localparam logic [7:0]  BROADCAST_ADDR = 8'd0;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 2'd2;

  // input word layout
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned IN_DATA_W = 48;

  // output word layout, lowest bit up
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned STAT_LSB   = 0;
  localparam int unsigned LEN_LSB    = 3;
  localparam int unsigned BUSY_LSB   = 12;
  localparam int unsigned RBYTE_LSB  = 13;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_ERROR = 2'd1,
    CMD_POLL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_UNICAST   = 3'd1,
    ST_BROADCAST = 3'd2,
    ST_REJECT    = 3'd3,
    ST_OTHER     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef struct packed {
    logic [15:0] bus_msgs;
    logic [15:0] comm_errs;
    logic [15:0] overruns;
    logic [15:0] srv_msgs;
  } counters_t;

endpackage

`default_nettype wire

// ----- hdl/mbrtu_ram.sv -----
// ----------------------------------------------------------------------------
// mbrtu_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/modbus_rtu_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver
// Modbus RTU framing with t1.5 / t3.5 timing, CRC-16 check and frame store.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one word per event. tuser holds the command (byte received, line
//   error, service poll, read stored byte); tdata holds data byte, tick time
//   and store index. m_axis: exactly one result word per input word, in order.
//   cfg: write enable, register index and data; write only while idle.
// Timing
//   One word accepted per cycle when the output side keeps up. A result
//   passes through the read stage, where the frame store read (registered
//   RAM) completes, and then through the output register.
//   Frame state, CRC and counters update in the cycle of acceptance, so the
//   next word sees them at once; the store write lands before any later read.
// Reset
//   Counters, frame state and registers return to their defaults; the frame
//   store is not cleared, so only bytes written since reset may be read back.
// Back-pressure
//   With m_axis_tready low, the output register and the read stage fill, then
//   s_axis_tready drops; no result is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_frame_receiver
  import mbrtu_pkg::*;
#(
  parameter int unsigned FRAME_MAX = FRAME_MAX_DEF,
  parameter int unsigned FRAME_MIN = FRAME_MIN_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: data_byte[7:0], tick_time[39:8], buffer_index[47:40]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  // output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: frame_status[2:0], frame_length[11:3], busy_res[12], read_byte[20:13],
  // bus_message_count[36:21], comm_error_count[52:37], overrun_count[68:53],
  // server_message_count[84:69], zero pad[87:85]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned AW = $clog2(FRAME_MAX);
  localparam int unsigned CW = $clog2(FRAME_MAX + 1);
  localparam int unsigned XW = (CW > 8) ? CW : 8;

  // byte-wise CRC-16/MODBUS
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // configuration registers
  logic [7:0]  unit_addr_q;
  logic [31:0] char_gap_q, frame_gap_q;

  // frame state
  logic          receiving_q, receiving_d;
  logic          bad_q, bad_d;
  logic          ovr_q, ovr_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   last_q, last_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    first_q, first_d;
  counters_t     cnt_q, cnt_d;

  // input fields
  cmd_e        cmd;
  logic [7:0]  data_byte;
  logic [31:0] tick_time;
  logic [7:0]  buffer_index;
  logic        in_acc;

  assign cmd          = cmd_e'(s_axis_tuser);
  assign data_byte    = s_axis_tdata[7:0];
  assign tick_time    = s_axis_tdata[39:8];
  assign buffer_index = s_axis_tdata[47:40];
  assign in_acc       = s_axis_tvalid && s_axis_tready;

  // timing and position
  logic [31:0]   elapsed;
  logic          gap_over, silence_ok, start, room, in_range, short_frame;
  logic [CW-1:0] cnt_base;
  logic [15:0]   crc_base;
  logic [XW-1:0] idx_x;

  assign elapsed     = tick_time - last_q;
  assign gap_over    = elapsed > char_gap_q;
  assign silence_ok  = elapsed >= frame_gap_q;
  assign start       = !receiving_q;
  assign cnt_base    = start ? '0 : count_q;
  assign crc_base    = start ? CRC_INIT : crc_q;
  assign room        = cnt_base < CW'(FRAME_MAX);
  assign idx_x       = XW'(buffer_index);
  assign in_range    = idx_x < XW'(FRAME_MAX);
  assign short_frame = XW'(count_q) < XW'(FRAME_MIN);

  // result of the current word
  status_e    res_status;
  logic [8:0] res_len;
  logic       res_rd;
  logic       ram_we, ram_re;

  // next state and result
  always_comb begin
    receiving_d = receiving_q;
    bad_d       = bad_q;
    ovr_d       = ovr_q;
    count_d     = count_q;
    last_d      = last_q;
    crc_d       = crc_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    res_status  = ST_NONE;
    res_len     = '0;
    res_rd      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (cmd)
      CMD_BYTE: begin
        receiving_d = 1'b1;
        bad_d       = (start ? 1'b0 : (bad_q | gap_over)) | !room;
        last_d      = tick_time;
        count_d     = cnt_base;
        crc_d       = crc_base;
        if (room) begin
          ram_we  = 1'b1;
          count_d = cnt_base + CW'(1);
          crc_d   = crc_byte(crc_base, data_byte);
          if (cnt_base == '0) begin
            first_d = data_byte;
          end
        end
      end
      CMD_ERROR: begin
        bad_d       = 1'b1;
        ovr_d       = 1'b1;
        receiving_d = 1'b1;
        last_d      = tick_time;
      end
      CMD_POLL: begin
        if (receiving_q && silence_ok) begin
          receiving_d = 1'b0;
          bad_d       = 1'b0;
          ovr_d       = 1'b0;
          count_d     = '0;
          crc_d       = CRC_INIT;
          res_len     = 9'(count_q);
          if (count_q == '0) begin
            res_status = ST_EMPTY;
          end else begin
            cnt_d.bus_msgs = cnt_q.bus_msgs + 16'd1;
            if (ovr_q) begin
              cnt_d.overruns = cnt_q.overruns + 16'd1;
            end
            priority if (bad_q || short_frame || crc_q != 16'd0) begin
              cnt_d.comm_errs = cnt_q.comm_errs + 16'd1;
              res_status      = ST_REJECT;
            end else if (first_q == BROADCAST_ADDR) begin
              cnt_d.srv_msgs = cnt_q.srv_msgs + 16'd1;
              res_status     = ST_BROADCAST;
            end else if (first_q == unit_addr_q) begin
              cnt_d.srv_msgs = cnt_q.srv_msgs + 16'd1;
              res_status     = ST_UNICAST;
            end else begin
              res_status = ST_OTHER;
            end
          end
        end
      end
      CMD_READ: begin
        res_rd = in_range;
        ram_re = 1'b1;
      end
      default: begin
        res_rd = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_addr_q <= UNIT_ADDR_RST;
      char_gap_q  <= CHAR_GAP_RST;
      frame_gap_q <= FRAME_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UNIT_ADDR: unit_addr_q <= cfg_data_i[7:0];
        REG_CHAR_GAP:  char_gap_q  <= cfg_data_i;
        REG_FRAME_GAP: frame_gap_q <= cfg_data_i;
        default:       unit_addr_q <= unit_addr_q;
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      bad_q       <= 1'b0;
      ovr_q       <= 1'b0;
      count_q     <= '0;
      last_q      <= '0;
      crc_q       <= CRC_INIT;
      first_q     <= '0;
      cnt_q       <= '0;
    end else if (in_acc) begin
      receiving_q <= receiving_d;
      bad_q       <= bad_d;
      ovr_q       <= ovr_d;
      count_q     <= count_d;
      last_q      <= last_d;
      crc_q       <= crc_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
    end
  end

  // frame store
  logic [7:0] ram_rdata;

  mbrtu_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && ram_we),
    .waddr_i (cnt_base[AW-1:0]),
    .wdata_i (data_byte),
    .re_i    (in_acc && ram_re),
    .raddr_i (idx_x[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // read stage: waits for the store read data
  logic       p1_v_q, p1_adv;
  status_e    p1_status_q;
  logic [8:0] p1_len_q;
  logic       p1_busy_q, p1_rd_q;
  counters_t  p1_cnt_q;

  // output register
  logic                  out_v_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [7:0]            rbyte;

  assign p1_adv        = p1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !p1_v_q || p1_adv;
  assign rbyte         = p1_rd_q ? ram_rdata : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        p1_v_q <= 1'b1;
      end else if (p1_adv) begin
        p1_v_q <= 1'b0;
      end
      if (p1_adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_status_q <= res_status;
      p1_len_q    <= res_len;
      p1_busy_q   <= receiving_d;
      p1_rd_q     <= res_rd;
      p1_cnt_q    <= cnt_d;
    end
    if (p1_adv) begin
      out_data_q <= {3'd0, p1_cnt_q.srv_msgs, p1_cnt_q.overruns, p1_cnt_q.comm_errs,
                     p1_cnt_q.bus_msgs, rbyte, p1_busy_q, p1_len_q, p1_status_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- hdl/mbrtu_checker.sv -----
// ----------------------------------------------------------------------------
// mbrtu_checker
// Port-level checks on the result stream of the Modbus RTU frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_checker
  import mbrtu_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [2:0] status;
  logic [8:0] length;
  logic       busy;

  assign status = m_axis_tdata[STAT_LSB +: 3];
  assign length = m_axis_tdata[LEN_LSB +: 9];
  assign busy   = m_axis_tdata[BUSY_LSB];

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // status code in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> status <= ST_EMPTY)
    else $error("frame status out of range");

  // a closed frame leaves the receiver idle
  a_closed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != ST_NONE |-> !busy)
    else $error("busy after frame close");

  // no length without a stored byte
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_NONE || status == ST_EMPTY) |-> length == 9'd0)
    else $error("length reported with no frame bytes");

endmodule

bind modbus_rtu_frame_receiver mbrtu_checker u_mbrtu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/modbus_rtu_frame_receiver_tb.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_tb
// Self-checking bench for the Modbus RTU frame receiver. A queue of event
// words (bytes, line errors, service polls, store reads) feeds a stream
// driver. A cycle-free predictor follows every accepted word and queues the
// result word due for it. A monitor compares each result word field by field.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module modbus_rtu_frame_receiver_tb;
  import mbrtu_pkg::*;

  localparam int unsigned FRAME_MAX  = FRAME_MAX_DEF;
  localparam int unsigned FRAME_MIN  = FRAME_MIN_DEF;
  localparam int          CLK_PERIOD = 8;
  localparam int          NUM_PHASES = 5;
  localparam int          PHASE_WORDS = 24;

  // result word layout above the read byte
  localparam int unsigned BUS_LSB  = RBYTE_LSB + 8;
  localparam int unsigned COMM_LSB = BUS_LSB + 16;
  localparam int unsigned OVR_LSB  = COMM_LSB + 16;
  localparam int unsigned SRV_LSB  = OVR_LSB + 16;
  localparam int unsigned PAD_LSB  = SRV_LSB + 16;

  typedef enum int {
    FAULT_NONE,
    FAULT_CRC,
    FAULT_GAP,
    FAULT_ERR,
    FAULT_TRUNC
  } fault_e;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  data;
    logic [31:0] now;
    logic [7:0]  idx;
  } rx_event_t;

  typedef struct {
    status_e     status;
    logic [8:0]  len;
    logic        busy;
    logic [7:0]  rbyte;
    logic [15:0] bus;
    logic [15:0] comm;
    logic [15:0] ovr;
    logic [15:0] srv;
  } frame_result_t;

  // clock, reset and block ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // register copies
  logic [7:0]  cfg_addr = UNIT_ADDR_RST;
  logic [31:0] cfg_t15  = CHAR_GAP_RST;
  logic [31:0] cfg_t35  = FRAME_GAP_RST;

  // predicted receiver state
  logic        rx_on    = 1'b0;
  logic        bad      = 1'b0;
  logic        ovr_seen = 1'b0;
  int          nbytes   = 0;
  logic [31:0] last_evt = '0;
  logic [15:0] crc      = CRC_INIT;
  logic [7:0]  addr0    = '0;
  logic [15:0] bus_cnt  = '0;
  logic [15:0] comm_cnt = '0;
  logic [15:0] ovr_cnt  = '0;
  logic [15:0] srv_cnt  = '0;
  logic [7:0]  store_img [FRAME_MAX];
  bit          store_set [FRAME_MAX];

  // queues and bookkeeping
  rx_event_t     event_q[$];
  frame_result_t result_due_q[$];
  rx_event_t     cur_ev;
  int            words_open   = 0;
  int            words_queued = 0;
  int            fail_count   = 0;
  int            src_hold     = 0;
  int            sink_hold    = 0;
  int            k;
  bit            quiet        = 1'b0;
  logic [31:0]   gen_tick     = '0;
  frame_result_t want;

  // phase settings: own address, t1.5, t3.5
  logic [7:0]  ph_addr [NUM_PHASES] = '{8'h5A, BROADCAST_ADDR, 8'hFF, 8'hA5, UNIT_ADDR_RST};
  logic [31:0] ph_t15  [NUM_PHASES] = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd20, CHAR_GAP_RST};
  logic [31:0] ph_t35  [NUM_PHASES] = '{32'd300, 32'd0, 32'hFFFF_FFFF, 32'd50, FRAME_GAP_RST};

  modbus_rtu_frame_receiver #(
    .FRAME_MAX (FRAME_MAX),
    .FRAME_MIN (FRAME_MIN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  task automatic report_fail(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_v);
    if (got !== exp_v) begin
      report_fail($sformatf("%s got %0h want %0h", name, got, exp_v));
    end
  endtask

  // receiver behaviour for one accepted word, queues the result due
  function automatic void receiver_step(input rx_event_t ev);
    frame_result_t r;
    logic [31:0]   dt;
    logic [15:0]   crc_was;
    logic          bad_was;
    logic          ovr_was;
    int            len;
    r.status = ST_NONE;
    r.len    = '0;
    r.rbyte  = '0;
    dt = ev.now - last_evt;
    case (ev.cmd)
      CMD_BYTE: begin
        if (rx_on) begin
          if (dt > cfg_t15) bad = 1'b1;
        end else begin
          rx_on  = 1'b1;
          nbytes = 0;
          bad    = 1'b0;
          crc    = CRC_INIT;
        end
        // bytes past the store size are dropped
        if (nbytes < FRAME_MAX) begin
          store_img[nbytes] = ev.data;
          store_set[nbytes] = 1'b1;
          if (nbytes == 0) addr0 = ev.data;
          crc = crc16_update(crc, ev.data);
          nbytes++;
        end else begin
          bad = 1'b1;
        end
        last_evt = ev.now;
      end
      CMD_ERROR: begin
        bad      = 1'b1;
        ovr_seen = 1'b1;
        rx_on    = 1'b1;
        last_evt = ev.now;
      end
      CMD_POLL: begin
        if (rx_on && dt >= cfg_t35) begin
          len     = nbytes;
          bad_was = bad;
          ovr_was = ovr_seen;
          crc_was = crc;
          rx_on    = 1'b0;
          bad      = 1'b0;
          ovr_seen = 1'b0;
          nbytes   = 0;
          crc      = CRC_INIT;
          r.len    = len[8:0];
          if (len == 0) begin
            r.status = ST_EMPTY;
          end else begin
            bus_cnt++;
            if (ovr_was) ovr_cnt++;
            if (bad_was || len < FRAME_MIN || crc_was != 16'h0000) begin
              comm_cnt++;
              r.status = ST_REJECT;
            end else if (addr0 != BROADCAST_ADDR && addr0 != cfg_addr) begin
              r.status = ST_OTHER;
            end else begin
              srv_cnt++;
              r.status = (addr0 == BROADCAST_ADDR) ? ST_BROADCAST : ST_UNICAST;
            end
          end
        end
      end
      default: begin
        r.rbyte = store_img[ev.idx];
      end
    endcase
    r.busy = rx_on;
    r.bus  = bus_cnt;
    r.comm = comm_cnt;
    r.ovr  = ovr_cnt;
    r.srv  = srv_cnt;
    result_due_q.push_back(r);
  endfunction

  function automatic void queue_word(input cmd_e cmd, input logic [7:0] data,
                                     input logic [31:0] now, input logic [7:0] idx);
    rx_event_t ev;
    ev.cmd  = cmd;
    ev.data = data;
    ev.now  = now;
    ev.idx  = idx;
    event_q.push_back(ev);
    words_open++;
    words_queued++;
  endfunction

  function automatic logic [31:0] char_delta();
    return $urandom_range(cfg_t15, 0);
  endfunction

  // optional early poll, then a poll once t3.5 has passed
  function automatic void close_frame(input bit early);
    if (early && cfg_t35 != 0) begin
      queue_word(CMD_POLL, 8'($urandom_range(255, 0)),
                 gen_tick + $urandom_range(cfg_t35 - 1, 0),
                 8'($urandom_range(255, 0)));
    end
    gen_tick = gen_tick + ((cfg_t35 > 32'hFFFF_FFC0) ? cfg_t35 : cfg_t35 + $urandom_range(63, 0));
    queue_word(CMD_POLL, 8'($urandom_range(255, 0)), gen_tick, 8'($urandom_range(255, 0)));
  endfunction

  // one frame: address, payload, crc low then high, then closing polls
  function automatic void add_frame(input logic [7:0] addr, input int payload_n,
                                    input fault_e fault, input bit early);
    logic [7:0]  fb[$];
    logic [15:0] c;
    fault_e      f;
    int          gap_at;
    int          err_at;
    int          n;
    f = fault;
    fb.push_back(addr);
    for (int i = 0; i < payload_n; i++) fb.push_back(8'($urandom_range(255, 0)));
    c = CRC_INIT;
    foreach (fb[i]) c = crc16_update(c, fb[i]);
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    // a gap over t1.5 cannot be made when t1.5 is near the top
    if (f == FAULT_GAP && cfg_t15 > 32'hFFFF_FF00) f = FAULT_CRC;
    if (f == FAULT_CRC) begin
      n = $urandom_range(fb.size() - 1, 0);
      fb[n] = fb[n] ^ (8'h01 << $urandom_range(7, 0));
    end
    if (f == FAULT_TRUNC) begin
      n = $urandom_range(FRAME_MIN - 1, 1);
      while (fb.size() > n) void'(fb.pop_back());
    end
    gap_at = (f == FAULT_GAP) ? $urandom_range(fb.size() - 1, 1) : -1;
    err_at = (f == FAULT_ERR) ? $urandom_range(fb.size() - 1, 0) : -1;
    foreach (fb[i]) begin
      if (i == err_at) begin
        gen_tick = gen_tick + char_delta();
        queue_word(CMD_ERROR, 8'($urandom_range(255, 0)), gen_tick,
                   8'($urandom_range(255, 0)));
      end
      if (i == 0 && err_at != 0) begin
        gen_tick = gen_tick + $urandom_range(255, 0);
      end else if (i == gap_at) begin
        gen_tick = gen_tick + cfg_t15 + 32'd1 + $urandom_range(100, 0);
      end else begin
        gen_tick = gen_tick + char_delta();
      end
      queue_word(CMD_BYTE, fb[i], gen_tick, 8'($urandom_range(255, 0)));
    end
    close_frame(early);
  endfunction

  function automatic void add_noise(input int n);
    for (int i = 0; i < n; i++) begin
      gen_tick = gen_tick + (($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(2000, 0));
      queue_word(cmd_e'($urandom_range(3, 0)), 8'($urandom_range(255, 0)), gen_tick,
                 8'($urandom_range(255, 0)));
    end
  endfunction

  function automatic void add_reads(input int n);
    for (int i = 0; i < n; i++) begin
      queue_word(CMD_READ, 8'($urandom_range(255, 0)), $urandom(),
                 8'($urandom_range(255, 0)));
    end
  endfunction

  // mostly well-formed frames, some broken ones, some noise and reads
  function automatic void run_random(input int n_words);
    int         stop_at;
    int         pick;
    logic [7:0] a;
    stop_at = words_queued + n_words;
    while (words_queued < stop_at) begin
      pick = $urandom_range(9, 0);
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4: a = cfg_addr;
        5, 6: a = BROADCAST_ADDR;
        7, 8: begin
          a = 8'($urandom_range(255, 0));
          while (a == cfg_addr || a == BROADCAST_ADDR) a = 8'($urandom_range(255, 0));
        end
        default: a = 8'($urandom_range(255, 0));
      endcase
      if (pick < 6) begin
        add_frame(a, $urandom_range(6, 1), FAULT_NONE, $urandom_range(3, 0) == 0);
      end else if (pick < 8) begin
        add_frame(a, $urandom_range(6, 1), fault_e'($urandom_range(4, 1)),
                  $urandom_range(3, 0) == 0);
      end else if (pick == 8) begin
        add_noise($urandom_range(4, 1));
      end else begin
        add_reads($urandom_range(3, 1));
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_UNIT_ADDR: cfg_addr = val[7:0];
      REG_CHAR_GAP:  cfg_t15  = val;
      REG_FRAME_GAP: cfg_t35  = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (words_open != 0 || result_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // stream driver: predicts on acceptance, then offers the next word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        receiver_step(cur_ev);
        words_open--;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_hold != 0) begin
          src_hold--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && event_q.size() != 0 && $urandom_range(5, 0) == 0) begin
          src_hold = $urandom_range(2, 0);
          s_axis_tvalid <= 1'b0;
        end else if (event_q.size() != 0) begin
          cur_ev = event_q.pop_front();
          // reads only target store entries written since reset
          if (cur_ev.cmd == CMD_READ) begin
            for (k = 0; k < FRAME_MAX; k++) begin
              if (!store_set[cur_ev.idx]) cur_ev.idx = cur_ev.idx + 8'd1;
            end
            if (!store_set[cur_ev.idx]) cur_ev.cmd = CMD_POLL;
          end
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_ev.idx, cur_ev.now, cur_ev.data};
          s_axis_tuser  <= cur_ev.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_due_q.size() == 0) begin
          report_fail($sformatf("result word with none due: %h", m_axis_tdata));
        end else begin
          want = result_due_q.pop_front();
          check_field("frame_status", 16'(m_axis_tdata[STAT_LSB +: 3]), 16'(want.status));
          check_field("frame_length", 16'(m_axis_tdata[LEN_LSB +: 9]), 16'(want.len));
          check_field("busy", 16'(m_axis_tdata[BUSY_LSB]), 16'(want.busy));
          check_field("read_byte", 16'(m_axis_tdata[RBYTE_LSB +: 8]), 16'(want.rbyte));
          check_field("bus_message_count", m_axis_tdata[BUS_LSB +: 16], want.bus);
          check_field("comm_error_count", m_axis_tdata[COMM_LSB +: 16], want.comm);
          check_field("overrun_count", m_axis_tdata[OVR_LSB +: 16], want.ovr);
          check_field("server_message_count", m_axis_tdata[SRV_LSB +: 16], want.srv);
          check_field("pad", 16'(m_axis_tdata[OUT_DATA_W-1:PAD_LSB]), 16'd0);
        end
      end
      if (sink_hold != 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(7, 0) == 0) begin
        sink_hold = $urandom_range(2, 0);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus sequence
  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    // directed words under the reset settings, time wraps early on
    gen_tick = 32'hFFFF_FC00;
    queue_word(CMD_POLL, 8'hFF, gen_tick, 8'h00);
    add_frame(UNIT_ADDR_RST, 1, FAULT_NONE, 1'b1);
    queue_word(CMD_READ, 8'h00, $urandom(), 8'd0);
    queue_word(CMD_READ, 8'hFF, $urandom(), 8'd3);
    add_frame(BROADCAST_ADDR, 1, FAULT_NONE, 1'b0);
    add_frame(8'h11, 1, FAULT_NONE, 1'b0);
    add_frame(8'hFF, 1, FAULT_TRUNC, 1'b0);
    add_frame(UNIT_ADDR_RST, 1, FAULT_GAP, 1'b0);
    // line error alone leaves an empty frame
    gen_tick = gen_tick + char_delta();
    queue_word(CMD_ERROR, 8'h00, gen_tick, 8'hFF);
    close_frame(1'b0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_UNIT_ADDR, {8'($urandom_range(255, 0)), 16'h0000, ph_addr[p]});
      write_reg(REG_CHAR_GAP, ph_t15[p]);
      write_reg(REG_FRAME_GAP, ph_t35[p]);
      gen_tick = $urandom();
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      // an overlong frame fills the whole store and drops its last byte
      if (p == 0) begin
        add_frame(cfg_addr, FRAME_MAX - 2, FAULT_NONE, 1'b0);
        add_reads(6);
      end
      run_random(PHASE_WORDS);
      wait_drained();
    end

    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
